/* hdl/i2cmts_pkg.sv */
// Shared types and constants of the I2C master transaction sequencer.
package i2cmts_pkg;

	localparam int MAX_STEPS_DEF = 4;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_EVENT   = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_CONT  = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [7:0] STATUS_MASK   = 8'hF8;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;

	localparam logic [7:0] REG_MEAS_HI = 8'h02;
	localparam logic [7:0] REG_MEAS_LO = 8'h03;
	localparam logic [7:0] READ_BIT    = 8'h01;

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_WAIT_START = 4'd1;
	localparam logic [3:0] PH_SEND_ADDR  = 4'd2;
	localparam logic [3:0] PH_ADDR_W     = 4'd3;
	localparam logic [3:0] PH_ADDR_R     = 4'd4;
	localparam logic [3:0] PH_SEND_DATA  = 4'd5;
	localparam logic [3:0] PH_DATA_ACK   = 4'd6;
	localparam logic [3:0] PH_STOP       = 4'd7;
	localparam logic [3:0] PH_RESTART    = 4'd8;
	localparam logic [3:0] PH_READ       = 4'd9;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slave_address;
		logic [7:0]  register_index;
		logic [7:0]  data_byte;
		logic [7:0]  bus_status;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  bus_command;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        write_done;
		logic        read_done;
		logic [15:0] read_value;
	} res_t;

endpackage

/* hdl/i2cmts_decide.sv */
// Combinational decision logic: next sequencer state and the result of one item.
module i2cmts_decide #(
	parameter int MAX_STEPS = i2cmts_pkg::MAX_STEPS_DEF,
	localparam int IDX_W = $clog2(MAX_STEPS)
) (
	input  i2cmts_pkg::item_t          item,
	input  logic [3:0]                 phase,
	input  logic [IDX_W-1:0]           step_index,
	input  logic [7:0]                 target_address,
	input  logic [MAX_STEPS-1:0]       is_read,
	input  logic [MAX_STEPS-1:0]       is_last,
	input  logic [MAX_STEPS-1:0][7:0]  tx_bytes,
	input  logic [MAX_STEPS-1:0][7:0]  rx_bytes,
	input  logic [15:0]                last_read_value,
	output logic [3:0]                 phase_nxt,
	output logic [IDX_W-1:0]           step_index_nxt,
	output logic [7:0]                 target_address_nxt,
	output logic [MAX_STEPS-1:0]       is_read_nxt,
	output logic [MAX_STEPS-1:0]       is_last_nxt,
	output logic [MAX_STEPS-1:0][7:0]  tx_bytes_nxt,
	output logic                       rx_we,
	output i2cmts_pkg::res_t           res
);
	import i2cmts_pkg::*;

	logic [7:0]       st;
	logic [IDX_W-1:0] k;
	logic [IDX_W-1:0] k_adv;
	logic [7:0]       rx_hi;
	logic [7:0]       rx_lo;

	assign st = item.bus_status & STATUS_MASK;
	assign k = step_index;
	assign k_adv = (k == IDX_W'(MAX_STEPS - 1)) ? '0 : k + IDX_W'(1);

	// Bytes of steps 1 and 3 as they stand after this event's write.
	always_comb begin
		rx_hi = 8'h00;
		rx_lo = 8'h00;
		for (int i = 0; i < MAX_STEPS; i++) begin
			if (i == 1) begin
				rx_hi = (k == IDX_W'(i)) ? item.rx_byte : rx_bytes[i];
			end
			if (i == 3) begin
				rx_lo = (k == IDX_W'(i)) ? item.rx_byte : rx_bytes[i];
			end
		end
	end

	always_comb begin
		phase_nxt = phase;
		step_index_nxt = step_index;
		target_address_nxt = target_address;
		is_read_nxt = is_read;
		is_last_nxt = is_last;
		tx_bytes_nxt = tx_bytes;
		rx_we = 1'b0;
		res = '0;
		res.read_value = last_read_value;

		if (item.op == OP_WRITE) begin
			phase_nxt = PH_WAIT_START;
			target_address_nxt = item.slave_address;
			res.bus_command = CMD_START;
			for (int i = 0; i < MAX_STEPS; i++) begin
				if (i == 0) begin
					is_read_nxt[i] = 1'b0;
					is_last_nxt[i] = 1'b0;
					tx_bytes_nxt[i] = item.register_index;
				end else if (i == 1) begin
					is_read_nxt[i] = 1'b0;
					is_last_nxt[i] = 1'b1;
					tx_bytes_nxt[i] = item.data_byte;
				end
			end
		end else if (item.op == OP_MEASURE) begin
			phase_nxt = PH_WAIT_START;
			target_address_nxt = item.slave_address;
			res.bus_command = CMD_START;
			for (int i = 0; i < MAX_STEPS; i++) begin
				if (i == 0) begin
					is_read_nxt[i] = 1'b0;
					is_last_nxt[i] = 1'b0;
					tx_bytes_nxt[i] = REG_MEAS_HI;
				end else if (i == 1) begin
					is_read_nxt[i] = 1'b1;
					is_last_nxt[i] = 1'b0;
				end else if (i == 2) begin
					is_read_nxt[i] = 1'b0;
					is_last_nxt[i] = 1'b0;
					tx_bytes_nxt[i] = REG_MEAS_LO;
				end else if (i == 3) begin
					is_read_nxt[i] = 1'b1;
					is_last_nxt[i] = 1'b1;
				end
			end
		end else if (item.op == OP_EVENT) begin
			unique case (phase)
				PH_IDLE: begin
					res.bus_command = CMD_START;
					phase_nxt = PH_WAIT_START;
				end
				PH_WAIT_START: begin
					phase_nxt = (st == ST_START || st == ST_RESTART) ? PH_SEND_ADDR : PH_IDLE;
				end
				PH_SEND_ADDR: begin
					res.tx_valid = 1'b1;
					res.bus_command = CMD_CONT;
					if (is_read[k]) begin
						res.tx_byte = target_address | READ_BIT;
						phase_nxt = PH_ADDR_R;
					end else begin
						res.tx_byte = target_address;
						phase_nxt = PH_ADDR_W;
					end
				end
				PH_ADDR_W: begin
					res.bus_command = CMD_CONT;
					phase_nxt = (st == ST_ADDR_W_ACK) ? PH_SEND_DATA : PH_SEND_ADDR;
				end
				PH_ADDR_R: begin
					res.bus_command = CMD_CONT;
					phase_nxt = (st == ST_ADDR_R_ACK) ? PH_READ : PH_SEND_ADDR;
				end
				PH_SEND_DATA: begin
					res.tx_valid = 1'b1;
					res.tx_byte = tx_bytes[k];
					res.bus_command = CMD_CONT;
					phase_nxt = PH_DATA_ACK;
				end
				PH_DATA_ACK: begin
					res.bus_command = CMD_CONT;
					if (st != ST_DATA_ACK) begin
						phase_nxt = PH_SEND_DATA;
					end else if (is_last[k]) begin
						phase_nxt = PH_STOP;
						res.write_done = 1'b1;
					end else begin
						phase_nxt = PH_RESTART;
						step_index_nxt = k_adv;
					end
				end
				PH_STOP: begin
					res.bus_command = CMD_STOP;
					phase_nxt = PH_IDLE;
					step_index_nxt = '0;
				end
				PH_RESTART: begin
					res.bus_command = CMD_START;
					phase_nxt = PH_WAIT_START;
				end
				PH_READ: begin
					rx_we = 1'b1;
					res.bus_command = CMD_CONT;
					if (is_last[k]) begin
						phase_nxt = PH_STOP;
						res.read_value = {rx_hi, rx_lo};
						res.read_done = 1'b1;
					end else begin
						phase_nxt = PH_RESTART;
						step_index_nxt = k_adv;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* hdl/i2cmts_outq.sv */
// Two-entry result buffer: output register plus skid register.
module i2cmts_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cmts_pkg::res_t  push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output i2cmts_pkg::res_t  out_data
);
	import i2cmts_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic pop;

	assign pop = main_valid_q & ~out_stall;
	assign full = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			// The skid entry is older than anything arriving now; it never
			// coexists with a push because a full skid stalls the input.
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* hdl/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master transaction sequencer.
//
// One input channel (in_valid / in_stall) carries commands and bus events:
// op 0 loads a register-write plan, op 1 a two-register measurement plan,
// op 2 reports a bus controller event with its status and received byte.
// Every accepted input beat produces exactly one output beat on the result
// channel (out_valid / out_stall) with the bus command, the byte to send,
// the done pulses and the held 16-bit measurement value.
// The sequencer state is updated and the result is registered at the
// edge that accepts the input beat. One beat is taken per cycle while
// in_stall is low; the decision logic feeding the output register is
// combinational.
// A stalled result waits in the output register while one more beat is
// taken into a skid register; in_stall rises only when both are occupied
// and falls the cycle after the receiver takes a beat.
// Reset clears the phase, step counter, target address, plan flags, the
// measurement value and the valid flags of both result registers. Plan
// bytes have no reset.
module i2c_master_transaction_sequencer #(
	parameter int MAX_STEPS = i2cmts_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  register_index,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  bus_status,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  bus_command,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        write_done,
	output logic        read_done,
	output logic [15:0] read_value
);
	import i2cmts_pkg::*;

	localparam int IDX_W = $clog2(MAX_STEPS);

	logic [3:0]                phase_q;
	logic [IDX_W-1:0]          step_index_q;
	logic [7:0]                target_address_q;
	logic [MAX_STEPS-1:0]      is_read_q;
	logic [MAX_STEPS-1:0]      is_last_q;
	logic [MAX_STEPS-1:0][7:0] tx_bytes_q;
	logic [MAX_STEPS-1:0][7:0] rx_bytes_q;
	logic [15:0]               last_read_value_q;

	logic [3:0]                phase_nxt;
	logic [IDX_W-1:0]          step_index_nxt;
	logic [7:0]                target_address_nxt;
	logic [MAX_STEPS-1:0]      is_read_nxt;
	logic [MAX_STEPS-1:0]      is_last_nxt;
	logic [MAX_STEPS-1:0][7:0] tx_bytes_nxt;
	logic                      rx_we;

	item_t item;
	res_t  res;
	res_t  out_data;
	logic  accept;
	logic  full;

	assign item = '{op: op, slave_address: slave_address, register_index: register_index,
		data_byte: data_byte, bus_status: bus_status, rx_byte: rx_byte};
	assign in_stall = full;
	assign accept = in_valid & ~full;

	i2cmts_decide #(
		.MAX_STEPS(MAX_STEPS)
	) u_decide (
		.item               (item),
		.phase              (phase_q),
		.step_index         (step_index_q),
		.target_address     (target_address_q),
		.is_read            (is_read_q),
		.is_last            (is_last_q),
		.tx_bytes           (tx_bytes_q),
		.rx_bytes           (rx_bytes_q),
		.last_read_value    (last_read_value_q),
		.phase_nxt          (phase_nxt),
		.step_index_nxt     (step_index_nxt),
		.target_address_nxt (target_address_nxt),
		.is_read_nxt        (is_read_nxt),
		.is_last_nxt        (is_last_nxt),
		.tx_bytes_nxt       (tx_bytes_nxt),
		.rx_we              (rx_we),
		.res                (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_index_q <= '0;
			target_address_q <= '0;
			is_read_q <= '0;
			is_last_q <= '0;
			last_read_value_q <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			step_index_q <= step_index_nxt;
			target_address_q <= target_address_nxt;
			is_read_q <= is_read_nxt;
			is_last_q <= is_last_nxt;
			last_read_value_q <= res.read_value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_bytes_q <= tx_bytes_nxt;
			if (rx_we) begin
				rx_bytes_q[step_index_q] <= rx_byte;
			end
		end
	end

	i2cmts_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign bus_command = out_data.bus_command;
	assign tx_valid = out_data.tx_valid;
	assign tx_byte = out_data.tx_byte;
	assign write_done = out_data.write_done;
	assign read_done = out_data.read_done;
	assign read_value = out_data.read_value;

endmodule

/* hdl/i2cmts_checker.sv */
// Port-level checks of the I2C master transaction sequencer, bound to the top level.
module i2cmts_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  bus_command,
	input logic        tx_valid,
	input logic [7:0]  tx_byte,
	input logic        write_done,
	input logic        read_done
);
	import i2cmts_pkg::*;

	// A waiting result stays presented until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// The input only stalls when a result is already waiting.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_done && read_done))
		else $error("write and read done in one beat");

	a_done_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (write_done || read_done) |-> bus_command == CMD_CONT && !tx_valid)
		else $error("done pulse with wrong command");

	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("tx byte set without tx valid");

endmodule

bind i2c_master_transaction_sequencer i2cmts_assertions u_i2cmts_assertions (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bus_command (bus_command),
	.tx_valid    (tx_valid),
	.tx_byte     (tx_byte),
	.write_done  (write_done),
	.read_done   (read_done)
);

/* bench/i2cmts_checker.sv */
// Watches both channels of the I2C sequencer, predicts each result beat and compares it.
module i2cmts_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  register_index,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  bus_status,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  bus_command,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        write_done,
	input  logic        read_done,
	input  logic [15:0] read_value,
	output int          mismatch_count,
	output int          actions_pending,
	output int          writes_seen,
	output int          reads_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import i2cmts_pkg::*;

	localparam int STEPS = MAX_STEPS_DEF;

	// Shadow copy of the sequencer state.
	logic [3:0]  phase;
	int unsigned step_at;
	logic [7:0]  target;
	logic        is_read [STEPS];
	logic        is_last [STEPS];
	logic [7:0]  tx_plan [STEPS];
	logic [7:0]  rx_plan [STEPS];
	logic [15:0] meas_value;

	res_t bus_actions_due [$];
	res_t due;

	function automatic void advance_step(input int unsigned k);
		step_at = (k + 1 >= STEPS) ? 0 : k + 1;
	endfunction

	function automatic res_t next_bus_action(input item_t it);
		res_t        r;
		logic [7:0]  st;
		int unsigned k;
		r = '0;
		st = it.bus_status & STATUS_MASK;
		k = (step_at < STEPS) ? step_at : 0;
		case (it.op)
			OP_WRITE: begin
				phase = PH_WAIT_START;
				target = it.slave_address;
				is_read[0] = 1'b0; is_last[0] = 1'b0;
				is_read[1] = 1'b0; is_last[1] = 1'b1;
				tx_plan[0] = it.register_index;
				tx_plan[1] = it.data_byte;
				r.bus_command = CMD_START;
			end
			OP_MEASURE: begin
				phase = PH_WAIT_START;
				target = it.slave_address;
				is_read[0] = 1'b0; is_last[0] = 1'b0;
				is_read[1] = 1'b1; is_last[1] = 1'b0;
				is_read[2] = 1'b0; is_last[2] = 1'b0;
				is_read[3] = 1'b1; is_last[3] = 1'b1;
				tx_plan[0] = REG_MEAS_HI;
				tx_plan[2] = REG_MEAS_LO;
				r.bus_command = CMD_START;
			end
			OP_EVENT: begin
				case (phase)
					PH_IDLE: begin
						r.bus_command = CMD_START;
						phase = PH_WAIT_START;
					end
					PH_WAIT_START: begin
						phase = (st == ST_START || st == ST_RESTART) ? PH_SEND_ADDR : PH_IDLE;
					end
					PH_SEND_ADDR: begin
						r.tx_valid = 1'b1;
						r.bus_command = CMD_CONT;
						if (is_read[k]) begin
							r.tx_byte = target | READ_BIT;
							phase = PH_ADDR_R;
						end else begin
							r.tx_byte = target;
							phase = PH_ADDR_W;
						end
					end
					PH_ADDR_W: begin
						r.bus_command = CMD_CONT;
						phase = (st == ST_ADDR_W_ACK) ? PH_SEND_DATA : PH_SEND_ADDR;
					end
					PH_ADDR_R: begin
						r.bus_command = CMD_CONT;
						phase = (st == ST_ADDR_R_ACK) ? PH_READ : PH_SEND_ADDR;
					end
					PH_SEND_DATA: begin
						r.tx_valid = 1'b1;
						r.tx_byte = tx_plan[k];
						r.bus_command = CMD_CONT;
						phase = PH_DATA_ACK;
					end
					PH_DATA_ACK: begin
						r.bus_command = CMD_CONT;
						if (st != ST_DATA_ACK) begin
							phase = PH_SEND_DATA;
						end else if (is_last[k]) begin
							phase = PH_STOP;
							r.write_done = 1'b1;
						end else begin
							phase = PH_RESTART;
							advance_step(k);
						end
					end
					PH_STOP: begin
						r.bus_command = CMD_STOP;
						phase = PH_IDLE;
						step_at = 0;
					end
					PH_RESTART: begin
						r.bus_command = CMD_START;
						phase = PH_WAIT_START;
					end
					PH_READ: begin
						rx_plan[k] = it.rx_byte;
						r.bus_command = CMD_CONT;
						if (is_last[k]) begin
							phase = PH_STOP;
							meas_value = {rx_plan[1], rx_plan[3]};
							r.read_done = 1'b1;
						end else begin
							phase = PH_RESTART;
							advance_step(k);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.read_value = meas_value;
		return r;
	endfunction

	function automatic bit field_ok(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("time %0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			step_at = 0;
			target = '0;
			meas_value = '0;
			for (int i = 0; i < STEPS; i++) begin
				is_read[i] = 1'b0;
				is_last[i] = 1'b0;
			end
			bus_actions_due.delete();
			actions_pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				bus_actions_due.push_back(next_bus_action({op, slave_address, register_index,
					data_byte, bus_status, rx_byte}));
			end
			if (out_valid && !out_stall) begin
				if (bus_actions_due.size() == 0) begin
					$display("time %0t: result beat with none expected, %s %0d tx %0d/0x%0h",
						$time, "actual cmd", bus_command, tx_valid, tx_byte);
					mismatch_count++;
				end else begin
					due = bus_actions_due.pop_front();
					if (!field_ok("bus_command", 16'(due.bus_command), 16'(bus_command)))
						mismatch_count++;
					if (!field_ok("tx_valid", 16'(due.tx_valid), 16'(tx_valid)))
						mismatch_count++;
					if (!field_ok("tx_byte", 16'(due.tx_byte), 16'(tx_byte)))
						mismatch_count++;
					if (!field_ok("write_done", 16'(due.write_done), 16'(write_done)))
						mismatch_count++;
					if (!field_ok("read_done", 16'(due.read_done), 16'(read_done)))
						mismatch_count++;
					if (!field_ok("read_value", due.read_value, read_value)) mismatch_count++;
					if (due.write_done) writes_seen++;
					if (due.read_done) reads_seen++;
				end
			end
			actions_pending <= bus_actions_due.size();
		end
	end

endmodule

/* bench/i2c_master_transaction_sequencer_tb.sv */
// Top of the I2C sequencer testbench: clock, reset, bus-event stimulus and the verdict.
module i2c_master_transaction_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cmts_pkg::*;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_NACK   = 8'h30;
	localparam int         HOLD_CYCLES    = 150;
	localparam int         BEATS_PER_MODE = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        out_stall = 1'b0;
	logic [1:0]  op = OP_EVENT;
	logic [7:0]  slave_address = '0;
	logic [7:0]  register_index = '0;
	logic [7:0]  data_byte = '0;
	logic [7:0]  bus_status = '0;
	logic [7:0]  rx_byte = '0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  bus_command;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        write_done;
	logic        read_done;
	logic [15:0] read_value;

	int mismatch_count, actions_pending, writes_seen, reads_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	int beats_sent = 0;
	int writes_planned = 0;
	int measures_planned = 0;

	always #2 clk = ~clk;

	i2c_master_transaction_sequencer i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .op, .slave_address, .register_index,
		.data_byte, .bus_status, .rx_byte, .out_valid, .out_stall, .bus_command,
		.tx_valid, .tx_byte, .write_done, .read_done, .read_value
	);

	i2cmts_checker i_checker (
		.clk, .arst_n, .in_valid, .in_stall, .op, .slave_address, .register_index,
		.data_byte, .bus_status, .rx_byte, .out_valid, .out_stall, .bus_command,
		.tx_valid, .tx_byte, .write_done, .read_done, .read_value,
		.mismatch_count, .actions_pending, .writes_seen, .reads_seen
	);

	// Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_done != hold_reqs) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Called at a clock edge; returns at the edge that accepts the beat.
	task automatic push_beat(input logic [1:0] b_op, input logic [7:0] b_addr,
			input logic [7:0] b_reg, input logic [7:0] b_dat, input logic [7:0] b_st,
			input logic [7:0] b_rx);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= b_op;
		slave_address <= b_addr;
		register_index <= b_reg;
		data_byte <= b_dat;
		bus_status <= b_st;
		rx_byte <= b_rx;
		do @(posedge clk); while (in_stall);
		if (b_op != OP_UNUSED) beats_sent++;
	endtask

	task automatic bus_event(input logic [7:0] st);
		push_beat(OP_EVENT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), st, 8'($urandom_range(0, 255)));
	endtask

	task automatic any_event();
		bus_event(8'($urandom_range(0, 255)));
	endtask

	task automatic start_plan(input logic [1:0] which);
		push_beat(which, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// A checked status: sometimes refused first, which sends the block one phase back,
	// so a filler event and a retry keep the script in step with the sequencer.
	task automatic status_slot(input logic [7:0] good_a, input logic [7:0] good_b);
		logic [7:0] bad;
		while ($urandom_range(0, 99) < 10) begin
			do bad = 8'($urandom_range(0, 255));
			while ((bad & STATUS_MASK) == good_a || (bad & STATUS_MASK) == good_b);
			bus_event(bad);
			any_event();
		end
		bus_event(($urandom_range(0, 1) ? good_a : good_b) | 8'($urandom_range(0, 7)));
	endtask

	task automatic write_step();
		status_slot(ST_START, ST_RESTART);
		any_event();
		status_slot(ST_ADDR_W_ACK, ST_ADDR_W_ACK);
		any_event();
		status_slot(ST_DATA_ACK, ST_DATA_ACK);
	endtask

	task automatic read_step();
		status_slot(ST_START, ST_RESTART);
		any_event();
		status_slot(ST_ADDR_R_ACK, ST_ADDR_R_ACK);
		any_event();
	endtask

	task automatic run_transaction();
		int kind;
		kind = int'($urandom_range(0, 99));
		if (kind < 10) begin
			repeat ($urandom_range(1, 4)) begin
				push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end else if (kind < 55) begin
			writes_planned++;
			start_plan(OP_WRITE);
			write_step();
			if ($urandom_range(0, 99) < 5) return;
			any_event();
			write_step();
			any_event();
		end else begin
			measures_planned++;
			start_plan(OP_MEASURE);
			write_step();
			any_event();
			read_step();
			// Breaking off here leaves the step counter mid-plan for the next start.
			if ($urandom_range(0, 99) < 5) return;
			any_event();
			write_step();
			any_event();
			read_step();
			any_event();
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (actions_pending != 0);
	endtask

	initial begin
		int goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a full register write with NACK retries and an unused op inside it.
		push_beat(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
		bus_event(ST_START);
		push_beat(OP_EVENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		bus_event(ST_ADDR_W_NACK);
		any_event();
		bus_event(ST_ADDR_W_ACK | 8'h07);
		any_event();
		bus_event(ST_DATA_NACK);
		any_event();
		bus_event(ST_DATA_ACK);
		push_beat(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		any_event();
		bus_event(ST_RESTART | 8'h07);
		any_event();
		bus_event(ST_ADDR_W_ACK);
		any_event();
		bus_event(ST_DATA_ACK | 8'h07);
		any_event();
		// An event while idle asks for a start; a wrong status then drops back to idle.
		any_event();
		bus_event(ST_ADDR_R_ACK);
		push_beat(OP_MEASURE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		bus_event(ST_START);
		any_event();
		bus_event(ST_ADDR_W_ACK);
		any_event();
		bus_event(ST_DATA_ACK);
		// New plan while the measurement sits between its first and second step.
		push_beat(OP_WRITE, 8'h5A, 8'hA5, 8'h3C, 8'h00, 8'h00);

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 37; recv_idle_pct <= 86; end
				1: begin send_idle_pct = 86; recv_idle_pct <= 37; end
				default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
			endcase
			hold_reqs <= hold_reqs + 1;
			goal = beats_sent + BEATS_PER_MODE;
			while (beats_sent < goal) run_transaction();
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Run covered %0d beats: %0d register write and %0d measurement plans,",
			beats_sent, writes_planned, measures_planned);
		$display("with %0d write and %0d measurement completions under varying back-pressure.",
			writes_seen, reads_seen);
		if (mismatch_count == 0 && actions_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", actions_pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
